// ===== sv/bfsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_pkg: shared types and constants for the shortest-path engine
// Sizes of the edge table and node set, item layouts and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bfsp_pkg;

	// Sizing of the stores.
	localparam int MAX_NODES   = 64;
	localparam int MAX_EDGES   = 256;
	localparam int WEIGHT_BITS = 16;

	// Fixed field widths of the items.
	localparam int NODE_FIELD_W   = 6;
	localparam int COUNT_FIELD_W  = 7;
	localparam int WEIGHT_FIELD_W = 16;
	localparam int DIST_W         = 32;

	// Derived internal widths.
	localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int EIDX_W = $clog2(MAX_EDGES);
	localparam int ECNT_W = $clog2(MAX_EDGES + 1);

	typedef enum logic [2:0] {
		ST_DIST   = 3'd0,
		ST_STORED = 3'd1,
		ST_FULL   = 3'd2,
		ST_CYCLE  = 3'd3,
		ST_BADSRC = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ADD_EDGE = 1'b0,
		CMD_RUN      = 1'b1
	} command_t;

	typedef struct packed {
		command_t                          command;
		logic [NODE_FIELD_W-1:0]           from_node;
		logic [NODE_FIELD_W-1:0]           to_node;
		logic signed [WEIGHT_FIELD_W-1:0]  weight;
		logic                              both_ways;
		logic [NODE_FIELD_W-1:0]           source_node;
		logic [COUNT_FIELD_W-1:0]          node_count;
	} cmd_item_t;

	typedef struct packed {
		status_t                    status;
		logic [NODE_FIELD_W-1:0]    node;
		logic signed [DIST_W-1:0]   distance;
		logic                       reachable;
		logic                       last;
	} res_item_t;

	// One stored edge.
	typedef struct packed {
		logic [NODE_FIELD_W-1:0]         from_node;
		logic [NODE_FIELD_W-1:0]         to_node;
		logic signed [WEIGHT_BITS-1:0]   weight;
	} edge_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_REV,
		S_INIT,
		S_EDGE_RD,
		S_DIST_RD,
		S_RELAX,
		S_DONE,
		S_OUT_RD,
		S_OUT_LD,
		S_EMIT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic    latch;
		logic    wr_fwd;
		logic    wr_rev;
		logic    init_run;
		logic    rd_edge;
		logic    rd_dist;
		logic    relax;
		logic    commit;
		logic    out_rd;
		logic    out_ld;
		logic    emit;
		status_t emit_status;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_run;
		logic both;
		logic full;
		logic bad_src;
		logic no_edges;
		logic edge_end;
		logic check;
		logic cycle;
		logic node_end;
		logic out_free;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== sv/bfsp_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_dpath: datapath of the shortest-path engine
// Holds the edge table, the distance memory with its valid bits, the pass
// and edge counters, the relaxation arithmetic and the result register.
// ----------------------------------------------------------------------------
module bfsp_dpath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bfsp_pkg::cmd_item_t  cmd,
	input  wire logic                 res_stall,
	input  wire bfsp_pkg::dp_cmd_t    dc,
	output bfsp_pkg::dp_stat_t        ds,
	output logic                      res_valid,
	output bfsp_pkg::res_item_t       res
);
	import bfsp_pkg::*;

	cmd_item_t                   item_q;
	edge_t                       edge_mem [MAX_EDGES];
	edge_t                       edge_q;
	logic [ECNT_W-1:0]           ecount_q;
	logic [EIDX_W-1:0]           eidx_q;
	logic signed [DIST_W-1:0]    dist_mem [MAX_NODES];
	logic [MAX_NODES-1:0]        dvalid_q;
	logic signed [DIST_W-1:0]    dfrom_q;
	logic signed [DIST_W-1:0]    dto_q;
	logic                        vfrom_q;
	logic                        vto_q;
	logic                        inrng_q;
	logic [COUNT_FIELD_W-1:0]    passes_q;
	logic                        check_q;
	logic                        cyc_run_q;
	logic                        cycle_found_q;
	logic [NODE_W-1:0]           nidx_q;
	logic                        out_valid_q;
	res_item_t                   out_q;

	logic [COUNT_FIELD_W-1:0]    n_eff;
	logic                        out_free;
	logic                        edge_end;
	logic signed [WEIGHT_BITS-1:0] w_in;
	logic signed [DIST_W:0]      sum;
	logic signed [DIST_W-1:0]    cand;
	logic                        improve;
	logic                        dwr_en;
	logic [NODE_W-1:0]           dwr_addr;
	logic signed [DIST_W-1:0]    dwr_data;
	logic [NODE_W-1:0]           rda_addr;
	edge_t                       ewr_data;

	always_comb begin
		if (item_q.node_count > COUNT_FIELD_W'(MAX_NODES)) begin
			n_eff = COUNT_FIELD_W'(MAX_NODES);
		end else begin
			n_eff = item_q.node_count;
		end
	end

	assign out_free = !out_valid_q || !res_stall;
	assign edge_end = (ECNT_W'(eidx_q) + ECNT_W'(1)) == ecount_q;
	assign w_in     = item_q.weight[WEIGHT_BITS-1:0];

	// Saturating candidate distance and the relaxation test.
	always_comb begin
		sum = {dfrom_q[DIST_W-1], dfrom_q}
			+ {{(DIST_W + 1 - WEIGHT_BITS){edge_q.weight[WEIGHT_BITS-1]}}, edge_q.weight};
		if (sum[DIST_W] != sum[DIST_W-1]) begin
			cand = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
		end else begin
			cand = sum[DIST_W-1:0];
		end
		improve = inrng_q && vfrom_q && (!vto_q || (cand < dto_q));
	end

	always_comb begin
		ds.is_run   = (item_q.command == CMD_RUN);
		ds.both     = item_q.both_ways;
		if (item_q.both_ways) begin
			ds.full = ecount_q > ECNT_W'(MAX_EDGES - 2);
		end else begin
			ds.full = ecount_q > ECNT_W'(MAX_EDGES - 1);
		end
		ds.bad_src  = COUNT_FIELD_W'(item_q.source_node) >= n_eff;
		ds.no_edges = (ecount_q == '0);
		ds.edge_end = edge_end;
		ds.check    = check_q;
		ds.cycle    = cyc_run_q;
		ds.node_end = (COUNT_FIELD_W'(nidx_q) + COUNT_FIELD_W'(1)) == n_eff;
		ds.out_free = out_free;
	end

	// Item capture.
	always_ff @(posedge clk) begin
		if (dc.latch) begin
			item_q <= cmd;
		end
	end

	// Edge table: one write port at the fill count, one registered read.
	always_comb begin
		if (dc.wr_rev) begin
			ewr_data = '{from_node: item_q.to_node, to_node: item_q.from_node, weight: w_in};
		end else begin
			ewr_data = '{from_node: item_q.from_node, to_node: item_q.to_node, weight: w_in};
		end
	end

	always_ff @(posedge clk) begin
		if (dc.wr_fwd || dc.wr_rev) begin
			edge_mem[ecount_q[EIDX_W-1:0]] <= ewr_data;
		end
		if (dc.rd_edge) begin
			edge_q <= edge_mem[eidx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecount_q <= '0;
		end else if (dc.wr_fwd || dc.wr_rev) begin
			ecount_q <= ecount_q + ECNT_W'(1);
		end
	end

	// Distance memory: one write port, two registered read ports.
	always_comb begin
		dwr_en   = dc.init_run || (dc.relax && improve);
		dwr_addr = dc.init_run ? item_q.source_node[NODE_W-1:0] : edge_q.to_node[NODE_W-1:0];
		dwr_data = dc.init_run ? '0 : cand;
		rda_addr = dc.out_rd ? nidx_q : edge_q.from_node[NODE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (dwr_en) begin
			dist_mem[dwr_addr] <= dwr_data;
		end
		if (dc.rd_dist || dc.out_rd) begin
			dfrom_q <= dist_mem[rda_addr];
		end
		if (dc.rd_dist) begin
			dto_q <= dist_mem[edge_q.to_node[NODE_W-1:0]];
		end
	end

	// Operand flags for the edge under relaxation.
	always_ff @(posedge clk) begin
		if (dc.rd_dist) begin
			vfrom_q <= dvalid_q[edge_q.from_node[NODE_W-1:0]];
			vto_q   <= dvalid_q[edge_q.to_node[NODE_W-1:0]];
			inrng_q <= (COUNT_FIELD_W'(edge_q.from_node) < n_eff)
				&& (COUNT_FIELD_W'(edge_q.to_node) < n_eff);
		end
	end

	// Run control: valid bits, edge and pass counters, verdicts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvalid_q      <= '0;
			eidx_q        <= '0;
			passes_q      <= '0;
			check_q       <= 1'b0;
			cyc_run_q     <= 1'b0;
			cycle_found_q <= 1'b0;
			nidx_q        <= '0;
		end else begin
			if (dc.init_run) begin
				// Only the source is reachable when a run starts.
				dvalid_q  <= {{(MAX_NODES-1){1'b0}}, 1'b1} << item_q.source_node[NODE_W-1:0];
				eidx_q    <= '0;
				passes_q  <= n_eff - COUNT_FIELD_W'(1);
				check_q   <= (n_eff == COUNT_FIELD_W'(1));
				cyc_run_q <= 1'b0;
				nidx_q    <= '0;
			end
			if (dc.relax) begin
				if (improve) begin
					dvalid_q[edge_q.to_node[NODE_W-1:0]] <= 1'b1;
					if (check_q) begin
						cyc_run_q <= 1'b1;
					end
				end
				if (edge_end) begin
					eidx_q <= '0;
					if (!check_q) begin
						passes_q <= passes_q - COUNT_FIELD_W'(1);
						if (passes_q == COUNT_FIELD_W'(1)) begin
							check_q <= 1'b1;
						end
					end
				end else begin
					eidx_q <= eidx_q + EIDX_W'(1);
				end
			end
			if (dc.commit) begin
				cycle_found_q <= cyc_run_q;
			end
			if (dc.out_ld) begin
				nidx_q <= nidx_q + NODE_W'(1);
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dc.out_ld || dc.emit) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dc.out_ld) begin
			out_q.status    <= ST_DIST;
			out_q.node      <= NODE_FIELD_W'(nidx_q);
			out_q.distance  <= dvalid_q[nidx_q] ? dfrom_q : '0;
			out_q.reachable <= dvalid_q[nidx_q];
			out_q.last      <= ds.node_end;
		end else if (dc.emit) begin
			out_q.status    <= dc.emit_status;
			out_q.node      <= '0;
			out_q.distance  <= '0;
			out_q.reachable <= 1'b0;
			out_q.last      <= 1'b1;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	// The stored verdict of the latest run is kept as block state.
	logic unused_cycle_found;
	assign unused_cycle_found = cycle_found_q;

endmodule
`default_nettype wire

// ===== sv/bfsp_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bfsp_ctrl: sequencer of the shortest-path engine
// Steps through edge loading, run setup, the relaxation passes, the check
// pass and the delivery of results, driving the datapath by commands.
// ----------------------------------------------------------------------------
module bfsp_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire bfsp_pkg::dp_stat_t  ds,
	output bfsp_pkg::dp_cmd_t        dc
);
	import bfsp_pkg::*;

	state_t  state_q, state_d;
	status_t emit_q, emit_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			emit_q  <= ST_STORED;
		end else begin
			state_q <= state_d;
			emit_q  <= emit_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		emit_d         = emit_q;
		dc             = '0;
		dc.emit_status = emit_q;
		cmd_stall      = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_valid) begin
					dc.latch = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (ds.is_run) begin
					if (ds.bad_src) begin
						emit_d  = ST_BADSRC;
						state_d = S_EMIT;
					end else begin
						state_d = S_INIT;
					end
				end else if (ds.full) begin
					emit_d  = ST_FULL;
					state_d = S_EMIT;
				end else begin
					dc.wr_fwd = 1'b1;
					emit_d    = ST_STORED;
					state_d   = ds.both ? S_ADD_REV : S_EMIT;
				end
			end
			S_ADD_REV: begin
				dc.wr_rev = 1'b1;
				state_d   = S_EMIT;
			end
			S_INIT: begin
				dc.init_run = 1'b1;
				state_d     = ds.no_edges ? S_DONE : S_EDGE_RD;
			end
			S_EDGE_RD: begin
				dc.rd_edge = 1'b1;
				state_d    = S_DIST_RD;
			end
			S_DIST_RD: begin
				dc.rd_dist = 1'b1;
				state_d    = S_RELAX;
			end
			S_RELAX: begin
				dc.relax = 1'b1;
				state_d  = (ds.edge_end && ds.check) ? S_DONE : S_EDGE_RD;
			end
			S_DONE: begin
				dc.commit = 1'b1;
				if (ds.cycle) begin
					emit_d  = ST_CYCLE;
					state_d = S_EMIT;
				end else begin
					state_d = S_OUT_RD;
				end
			end
			S_OUT_RD: begin
				dc.out_rd = 1'b1;
				state_d   = S_OUT_LD;
			end
			S_OUT_LD: begin
				if (ds.out_free) begin
					dc.out_ld = 1'b1;
					state_d   = ds.node_end ? S_IDLE : S_OUT_RD;
				end
			end
			S_EMIT: begin
				if (ds.out_free) begin
					dc.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/bellman_ford_shortest_paths.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bellman_ford_shortest_paths: single-source shortest paths engine
// Stores weighted edges and, on a run item, computes distances from a source
// by repeated edge relaxation, with a negative-cycle check.
// ----------------------------------------------------------------------------
// An add-edge item stores one edge, or a forward and a reverse edge when
// both_ways is set, and answers with one item: edge stored, or table full
// when the remaining slots do not hold the whole edge. A run item clears all
// distances, seeds the source at zero and relaxes every stored edge in the
// order it was stored, node_count-1 times, followed by one check pass. Edges
// with an endpoint at or above the node count are skipped; a node_count above
// the node capacity counts as the capacity. The run answers with one
// negative-cycle item, one bad-source item, or one distance item per node
// with last set on the final node; distances saturate to the signed 32-bit
// range. Each edge visit steps through the edge table read, the two-port
// distance memory read, and the relaxation with its write back. A new item
// is taken as soon as the sequencer is idle, even while the previous result
// still sits in the output register.
// ----------------------------------------------------------------------------
module bellman_ford_shortest_paths (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_stall,
	input  wire bfsp_pkg::cmd_item_t  cmd,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output bfsp_pkg::res_item_t       res
);
	import bfsp_pkg::*;

	// Command bundle from the sequencer and status bundle back to it.
	dp_cmd_t  dc;
	dp_stat_t ds;

	bfsp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.ds        (ds),
		.dc        (dc)
	);

	// The datapath owns both memories and the result register.
	bfsp_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res_stall (res_stall),
		.dc        (dc),
		.ds        (ds),
		.res_valid (res_valid),
		.res       (res)
	);

endmodule
`default_nettype wire
